// ===== rtl/wbfhd_pkg.sv =====
// Package for the weight-budget FIFO with head drop.
// Holds the transaction structs, event and register codes and defaults; no dependencies.
package wbfhd_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int TAG_W    = 8;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W    = 20;
  localparam int KIND_W   = 3;

  localparam logic [SUM_W-1:0] WEIGHT_LIMIT_RST = SUM_W'(1000);

  // Configuration register indexes
  localparam logic CFG_AUTO_DROP    = 1'b0;
  localparam logic CFG_WEIGHT_LIMIT = 1'b1;

  // Request types
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_DEPART = 1'b1;

  // Result event kinds
  localparam logic [KIND_W-1:0] EV_DROPPED  = 3'd0;
  localparam logic [KIND_W-1:0] EV_ACCEPTED = 3'd1;
  localparam logic [KIND_W-1:0] EV_REJECTED = 3'd2;
  localparam logic [KIND_W-1:0] EV_DEPARTED = 3'd3;
  localparam logic [KIND_W-1:0] EV_EMPTY    = 3'd4;

  typedef struct packed {
    logic                req_type;
    logic [TAG_W-1:0]    entry_tag;
    logic [WEIGHT_W-1:0] entry_weight;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   event_kind;
    logic [TAG_W-1:0]    out_tag;
    logic [WEIGHT_W-1:0] out_weight;
    logic [SUM_W-1:0]    total_weight;
    logic                last;
  } out_item_t;

  // One queued entry as held by a cell
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [WEIGHT_W-1:0] weight;
  } entry_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== rtl/wbfhd_cell.sv =====
// One storage cell of the shifting queue chain.
// Depends on wbfhd_pkg for entry_t and cell_ctrl_t.
module wbfhd_cell (
  input  logic                 clk,
  input  wbfhd_pkg::cell_ctrl_t ctrl,
  input  wbfhd_pkg::entry_t    load_data,
  input  wbfhd_pkg::entry_t    next_data,
  output wbfhd_pkg::entry_t    data
);
  import wbfhd_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  // Take the neighbor's entry on a pop, the new entry when this cell is the tail
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift) begin
      data_nxt = next_data;
    end else if (ctrl.load) begin
      data_nxt = load_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/weight_budget_fifo_head_drop_top.sv =====
// Weight-budget FIFO with head drop: a shifting chain of cells, head in cell 0.
// The result is registered: it lands in the output register when the request is accepted.
// Input: a request is taken when the output is free; head drops stall the input, since
// the cell chain shifts by one entry per cycle, and only while the output is free.
// Reset: clears control, entry count, weight total and configuration to defaults;
// cell contents are left as they are.
module weight_budget_fifo_head_drop_top #(
  parameter int QUEUE_DEPTH = wbfhd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wbfhd_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wbfhd_pkg::out_item_t              out_data,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [wbfhd_pkg::SUM_W-1:0]       cfg_wdata
);
  import wbfhd_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DROP = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic             auto_drop_r;
  logic [SUM_W-1:0] limit_r;
  in_item_t         req_r;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r;

  logic             out_free;
  logic             step_go;
  in_item_t         cur;
  logic             pop, push, done;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat, sum_sub;
  logic             drop_cond;
  entry_t           head;
  entry_t           new_entry;

  entry_t           cell_q [QUEUE_DEPTH];
  cell_ctrl_t       cell_c [QUEUE_DEPTH];

  // Output register is free when empty or being taken
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign step_go  = out_free && ((state_r == ST_IDLE && in_valid) || state_r == ST_DROP);

  // Select the request in work: the incoming one or the held add
  always_comb begin
    if (state_r == ST_IDLE) begin
      cur = in_data;
    end else begin
      cur = req_r;
    end
  end

  assign head            = cell_q[0];
  assign new_entry.tag    = cur.entry_tag;
  assign new_entry.weight = cur.entry_weight;

  assign sum_add   = {1'b0, sum_r} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, cur.entry_weight};
  assign sum_sat   = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign sum_sub   = (sum_r >= {{(SUM_W - WEIGHT_W){1'b0}}, head.weight}) ?
                     (sum_r - {{(SUM_W - WEIGHT_W){1'b0}}, head.weight}) : '0;
  assign drop_cond = auto_drop_r && (count_r != '0) && (sum_add > {1'b0, limit_r});

  // Work out one result of the current request
  always_comb begin
    pop     = 1'b0;
    push    = 1'b0;
    done    = 1'b1;
    sum_nxt = sum_r;
    out_nxt.event_kind   = EV_ACCEPTED;
    out_nxt.out_tag      = cur.entry_tag;
    out_nxt.out_weight   = cur.entry_weight;
    out_nxt.last         = 1'b1;
    if (cur.req_type == REQ_DEPART) begin
      if (count_r == '0) begin
        out_nxt.event_kind = EV_EMPTY;
        out_nxt.out_tag    = '0;
        out_nxt.out_weight = '0;
      end else begin
        pop                = 1'b1;
        sum_nxt            = sum_sub;
        out_nxt.event_kind = EV_DEPARTED;
        out_nxt.out_tag    = head.tag;
        out_nxt.out_weight = head.weight;
      end
    end else if (drop_cond) begin
      pop                = 1'b1;
      done               = 1'b0;
      sum_nxt            = sum_sub;
      out_nxt.event_kind = EV_DROPPED;
      out_nxt.out_tag    = head.tag;
      out_nxt.out_weight = head.weight;
      out_nxt.last       = 1'b0;
    end else if (count_r == CNT_W'(QUEUE_DEPTH)) begin
      out_nxt.event_kind = EV_REJECTED;
    end else begin
      push    = 1'b1;
      sum_nxt = sum_sat;
    end
    out_nxt.total_weight = sum_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    if (step_go) begin
      state_nxt = done ? ST_IDLE : ST_DROP;
      if (pop) begin
        count_nxt = count_r - CNT_W'(1);
      end else if (push) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  // Build the cell chain; the last cell refills from itself on a shift
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t next_d;
    if (i == QUEUE_DEPTH - 1) begin : g_end
      assign next_d = cell_q[i];
    end else begin : g_mid
      assign next_d = cell_q[i+1];
    end
    assign cell_c[i].shift = step_go && pop;
    assign cell_c[i].load  = step_go && push && (count_r == CNT_W'(i));
    wbfhd_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_c[i]),
      .load_data (new_entry),
      .next_data (next_d),
      .data      (cell_q[i])
    );
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (step_go) begin
        sum_r       <= sum_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_drop_r <= 1'b0;
      limit_r     <= WEIGHT_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_DROP:    auto_drop_r <= cfg_wdata[0];
        CFG_WEIGHT_LIMIT: limit_r     <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  // Hold the add request and the result payload
  always_ff @(posedge clk) begin
    if (step_go && state_r == ST_IDLE) begin
      req_r <= in_data;
    end
    if (step_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_not_last_is_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.last |-> out_r.event_kind == EV_DROPPED)
    else $error("non-final result is not a drop");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.event_kind == EV_EMPTY |->
      out_r.total_weight == '0 && out_r.out_tag == '0)
    else $error("empty report with nonzero payload");

  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DROP |-> in_stall)
    else $error("input taken during head drops");
`endif

endmodule
